// File: hw/rtl/pel_pkg.sv
// Package for the profile edge locator.
// Holds the configuration and result types, register indexes and pick-rule codes.
// No dependencies; used by every module of the block.
package pel_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned COORD_W = 20;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned THR_W   = 8;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 32;

    typedef enum logic [1:0] {
        REG_POLARITY = 2'd0,
        REG_PICK     = 2'd1,
        REG_THRESH   = 2'd2,
        REG_SUBPIX   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PICK_FIRST     = 2'd0,
        PICK_LAST      = 2'd1,
        PICK_STRONGEST = 2'd2,
        PICK_RESERVED  = 2'd3
    } t_pick;

    localparam logic POL_RISING  = 1'b0;
    localparam logic POL_FALLING = 1'b1;

    typedef struct packed {
        logic               polarity;
        t_pick              pick;
        logic [THR_W-1:0]   threshold;
        logic               subpixel;
    } t_cfg;

    typedef struct packed {
        logic                 found;
        logic [POINT_W-1:0]   x;
        logic [POINT_W-1:0]   y;
        logic [VALUE_W-1:0]   strength;
        logic [INDEX_W-1:0]   index;
    } t_result;

endpackage

// File: hw/rtl/pel_cfg_regs.sv
// APB-style configuration registers of the profile edge locator.
// Depends on pel_pkg for the register indexes and the configuration struct.
module pel_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [pel_pkg::APB_AW-1:0]   i_paddr,
    input  logic [pel_pkg::APB_DW-1:0]   i_pwdata,
    output logic [pel_pkg::APB_DW-1:0]   o_prdata,
    output logic                         o_pready,
    output pel_pkg::t_cfg                o_cfg
);

    pel_pkg::t_cfg     r_cfg;
    pel_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx    = pel_pkg::t_reg_idx'(i_paddr[3:2]);
    assign o_pready = 1'b1;
    assign w_wr     = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polarity  <= pel_pkg::POL_RISING;
            r_cfg.pick      <= pel_pkg::PICK_FIRST;
            r_cfg.threshold <= '0;
            r_cfg.subpixel  <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                pel_pkg::REG_POLARITY: r_cfg.polarity  <= i_pwdata[0];
                pel_pkg::REG_PICK:     r_cfg.pick      <= pel_pkg::t_pick'(i_pwdata[1:0]);
                pel_pkg::REG_THRESH:   r_cfg.threshold <= i_pwdata[pel_pkg::THR_W-1:0];
                pel_pkg::REG_SUBPIX:   r_cfg.subpixel  <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (w_idx)
            pel_pkg::REG_POLARITY: o_prdata[0]   = r_cfg.polarity;
            pel_pkg::REG_PICK:     o_prdata[1:0] = r_cfg.pick;
            pel_pkg::REG_THRESH:   o_prdata[pel_pkg::THR_W-1:0] = r_cfg.threshold;
            pel_pkg::REG_SUBPIX:   o_prdata[0]   = r_cfg.subpixel;
            default:               o_prdata      = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/pel_edge_core.sv
// Edge search core: input register, step compare and best-edge tracking.
// Depends on pel_pkg; emits one result per profile on the sample marked last.
module pel_edge_core #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pel_pkg::t_cfg                   i_cfg,
    input  logic                            i_in_accept,
    input  logic [pel_pkg::VALUE_W-1:0]     i_value,
    input  logic [pel_pkg::COORD_W-1:0]     i_x,
    input  logic [pel_pkg::COORD_W-1:0]     i_y,
    input  logic                            i_last,
    output logic                            o_held_last,
    output logic                            o_push,
    output pel_pkg::t_result                o_result
);

    localparam int unsigned IDX_CAP   = (1 << pel_pkg::INDEX_W) - 1;
    localparam int unsigned IDX_LIMIT = (MAX_SAMPLES - 1 > IDX_CAP) ? IDX_CAP : MAX_SAMPLES - 1;
    localparam logic [pel_pkg::INDEX_W-1:0] IdxLimit = pel_pkg::INDEX_W'(IDX_LIMIT);

    // input register
    logic                          r_in_valid;
    logic [pel_pkg::VALUE_W-1:0]   r_value;
    logic [pel_pkg::COORD_W-1:0]   r_x;
    logic [pel_pkg::COORD_W-1:0]   r_y;
    logic                          r_last;

    // profile state
    logic                          r_have_prev;
    logic [pel_pkg::VALUE_W-1:0]   r_prev_value;
    logic [pel_pkg::COORD_W-1:0]   r_prev_x;
    logic [pel_pkg::COORD_W-1:0]   r_prev_y;
    logic [pel_pkg::INDEX_W-1:0]   r_count;
    pel_pkg::t_result              r_best;

    logic                          n_have_prev;
    logic [pel_pkg::INDEX_W-1:0]   n_count;
    pel_pkg::t_result              n_best;

    logic signed [pel_pkg::VALUE_W:0] w_delta;
    logic signed [pel_pkg::VALUE_W:0] w_thr;
    logic [pel_pkg::VALUE_W:0]        w_abs;
    logic                             w_match;
    logic                             w_take;
    logic [pel_pkg::VALUE_W-1:0]      w_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_value <= i_value;
            r_x     <= i_x;
            r_y     <= i_y;
            r_last  <= i_last;
        end
    end

    always_comb begin
        w_delta    = $signed({1'b0, r_value}) - $signed({1'b0, r_prev_value});
        w_thr      = $signed({1'b0, i_cfg.threshold, 8'h00});
        w_abs      = w_delta[pel_pkg::VALUE_W] ? 17'(-w_delta) : 17'(w_delta);
        w_strength = w_abs[pel_pkg::VALUE_W-1:0];

        if (i_cfg.polarity == pel_pkg::POL_RISING) begin
            w_match = r_have_prev && (w_delta >= w_thr);
        end else begin
            w_match = r_have_prev && (w_delta <= -w_thr);
        end

        case (i_cfg.pick)
            pel_pkg::PICK_FIRST: w_take = !r_best.found;
            pel_pkg::PICK_LAST:  w_take = 1'b1;
            default:             w_take = !r_best.found || (w_strength > r_best.strength);
        endcase
        w_take = w_take && w_match;

        n_best = r_best;
        if (w_take) begin
            n_best.found    = 1'b1;
            n_best.strength = w_strength;
            n_best.index    = r_count;
            if (i_cfg.subpixel && (w_delta != '0)) begin
                // midpoint of the pair in Q20.1
                n_best.x = {1'b0, r_prev_x} + {1'b0, r_x};
                n_best.y = {1'b0, r_prev_y} + {1'b0, r_y};
            end else begin
                n_best.x = {r_x, 1'b0};
                n_best.y = {r_y, 1'b0};
            end
        end

        n_have_prev = 1'b1;
        n_count     = (r_count < IdxLimit) ? r_count + 1'b1 : r_count;

        o_result = n_best.found ? n_best : '0;
        o_push   = r_in_valid && r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_prev_value <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_count      <= '0;
            r_best       <= '0;
        end else if (r_in_valid) begin
            if (r_last) begin
                // end of profile: back to the cleared state
                r_have_prev  <= 1'b0;
                r_prev_value <= '0;
                r_prev_x     <= '0;
                r_prev_y     <= '0;
                r_count      <= '0;
                r_best       <= '0;
            end else begin
                r_have_prev  <= n_have_prev;
                r_prev_value <= r_value;
                r_prev_x     <= r_x;
                r_prev_y     <= r_y;
                r_count      <= n_count;
                r_best       <= n_best;
            end
        end
    end

    assign o_held_last = r_in_valid && r_last;

endmodule

// File: hw/rtl/pel_out_fifo.sv
// Three-beat result queue between the edge core and the output stream.
// Depends on pel_pkg for the result struct.
module pel_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pel_pkg::t_result  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output pel_pkg::t_result  o_data,
    output logic [1:0]        o_count
);

    localparam int unsigned DEPTH = 3;

    pel_pkg::t_result r_mem [DEPTH];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_pop;

    assign w_pop = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: hw/rtl/profile_edge_locator.sv
// Profile edge locator: one-dimensional caliper edge search over a sample stream.
// Takes one sample beat per cycle while tready is high; each beat is registered and compared
// with the previous sample, and the beat marked tlast yields one result beat, which is then
// written into the result buffer. Results queue in that three-beat buffer, so samples keep
// flowing while results wait; tready drops only when that buffer could overflow. The step
// threshold is in units of 256 grey levels; subpixel mode reports the pair midpoint in Q20.1.
// The user must write registers over the APB-style port only between profiles; the block itself does not enforce this.
// Depends on pel_pkg, pel_cfg_regs, pel_edge_core and pel_out_fifo.
module profile_edge_locator #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pel_pkg::S_TDATA_W-1:0]   i_s_tdata,   // sample_value[15:0], sample_x[35:16], sample_y[55:36]
    input  logic                            i_s_tlast,   // last_sample
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pel_pkg::M_TDATA_W-1:0]   o_m_tdata,   // edge_x[20:0], edge_y[41:21], edge_strength[57:42], edge_index[69:58], zero[71:70]
    output logic                            o_m_tuser,   // edge_found
    // configuration
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [pel_pkg::APB_AW-1:0]      i_paddr,
    input  logic [pel_pkg::APB_DW-1:0]      i_pwdata,
    output logic [pel_pkg::APB_DW-1:0]      o_prdata,
    output logic                            o_pready
);

    pel_pkg::t_cfg    w_cfg;
    pel_pkg::t_result w_core_result;
    pel_pkg::t_result w_out_result;
    logic             w_in_accept;
    logic             w_held_last;
    logic             w_push;
    logic             w_out_valid;
    logic [1:0]       w_count;

    // hold off while queued results plus one in flight could fill the buffer
    assign o_s_tready  = !(w_count == 2'd3) && !((w_count == 2'd2) && w_held_last);
    assign w_in_accept = i_s_tvalid && o_s_tready;

    pel_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    pel_edge_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_accept (w_in_accept),
        .i_value     (i_s_tdata[15:0]),
        .i_x         (i_s_tdata[35:16]),
        .i_y         (i_s_tdata[55:36]),
        .i_last      (i_s_tlast),
        .o_held_last (w_held_last),
        .o_push      (w_push),
        .o_result    (w_core_result)
    );

    pel_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_core_result),
        .i_pop   (i_m_tready),
        .o_valid (w_out_valid),
        .o_data  (w_out_result),
        .o_count (w_count)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tuser  = w_out_result.found;
    assign o_m_tdata  = {2'b00, w_out_result.index, w_out_result.strength,
                         w_out_result.y, w_out_result.x};

endmodule

// File: bench/testbench.sv
// Self-checking bench for profile_edge_locator: drives sample beats, predicts edge reports.
// Covers directed corner profiles, one long profile and random config phases.
// Depends on pel_pkg and the profile_edge_locator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pel_pkg::*;

    localparam int unsigned MAX_SAMPLES  = 4096;
    localparam int unsigned INDEX_LIMIT  = (MAX_SAMPLES - 1 > 4095) ? 4095 : MAX_SAMPLES - 1;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned LONG_PROFILE = 200;

    typedef struct packed {
        logic                 last;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   x;
        logic [VALUE_W-1:0]   value;
    } t_sample;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata  = '0;
    logic                   i_s_tlast  = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_psel     = 1'b0;
    logic                   i_penable  = 1'b0;
    logic                   i_pwrite   = 1'b0;
    logic [APB_AW-1:0]      i_paddr    = '0;
    logic [APB_DW-1:0]      i_pwdata   = '0;
    logic [APB_DW-1:0]      o_prdata;
    logic                   o_pready;

    profile_edge_locator #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // shadow of the register file, reset values
    t_cfg cfg = '{polarity: POL_RISING, pick: PICK_FIRST, threshold: '0, subpixel: 1'b1};

    // profile tracking state
    logic                 have_prev;
    logic [VALUE_W-1:0]   prev_value;
    logic [COORD_W-1:0]   prev_x;
    logic [COORD_W-1:0]   prev_y;
    logic [INDEX_W-1:0]   sample_idx;
    t_result              best_edge;

    t_sample  pending_samples[$];
    t_sample  shown = '0;
    t_result  edge_reports_due[$];

    bit  s_beat_taken = 0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  rx_hold      = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  mismatches   = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_profile();
        have_prev  = 1'b0;
        prev_value = '0;
        prev_x     = '0;
        prev_y     = '0;
        sample_idx = '0;
        best_edge  = '0;
    endfunction

    // Advance the profile by one accepted sample; queue a report on the last one.
    function automatic void track_sample(t_sample s);
        int                 delta;
        int                 thr;
        int                 mag;
        logic               hit;
        logic               take;
        logic [VALUE_W-1:0] strength;
        if (have_prev) begin
            delta = int'(s.value) - int'(prev_value);
            thr   = int'(cfg.threshold) * 256;
            hit   = (cfg.polarity == POL_RISING) ? (delta >= thr) : (delta <= -thr);
            if (hit) begin
                mag      = (delta < 0) ? -delta : delta;
                strength = VALUE_W'(mag);
                if (!best_edge.found)
                    take = 1'b1;
                else begin
                    case (cfg.pick)
                        PICK_FIRST: take = 1'b0;
                        PICK_LAST:  take = 1'b1;
                        default:    take = strength > best_edge.strength;
                    endcase
                end
                if (take) begin
                    best_edge.found = 1'b1;
                    if (cfg.subpixel && delta != 0) begin
                        best_edge.x = {1'b0, prev_x} + {1'b0, s.x};
                        best_edge.y = {1'b0, prev_y} + {1'b0, s.y};
                    end else begin
                        best_edge.x = {s.x, 1'b0};
                        best_edge.y = {s.y, 1'b0};
                    end
                    best_edge.strength = strength;
                    best_edge.index    = sample_idx;
                end
            end
        end
        prev_value = s.value;
        prev_x     = s.x;
        prev_y     = s.y;
        have_prev  = 1'b1;
        if (sample_idx < INDEX_W'(INDEX_LIMIT))
            sample_idx = sample_idx + 1'b1;
        if (s.last) begin
            edge_reports_due.insert(edge_reports_due.size(), best_edge);
            clear_profile();
        end
    endfunction

    function automatic void report_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: want found=%0d x=%h y=%h str=%h idx=%0d",
                     $realtime, what, want.found, want.x, want.y, want.strength, want.index);
            $display("    got found=%0d x=%h y=%h str=%h idx=%0d",
                     got.found, got.x, got.y, got.strength, got.index);
        end
    endfunction

    always @(posedge i_clk) begin : check_reports
        t_sample  s;
        t_result  got;
        t_result  want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                s = '{last: i_s_tlast, y: i_s_tdata[55:36], x: i_s_tdata[35:16],
                      value: i_s_tdata[15:0]};
                track_sample(s);
                s_beat_taken = 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.found    = o_m_tuser;
                got.x        = o_m_tdata[20:0];
                got.y        = o_m_tdata[41:21];
                got.strength = o_m_tdata[57:42];
                got.index    = o_m_tdata[69:58];
                if (edge_reports_due.size() == 0)
                    report_mismatch("unexpected edge report", '0, got);
                else begin
                    want = edge_reports_due.pop_front();
                    if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
                        got.strength !== want.strength || got.index !== want.index)
                        report_mismatch("edge report mismatch", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_samples
        logic     nv;
        t_sample  ns;
        nv = i_s_tvalid;
        ns = shown;
        if (i_rst_n && (!i_s_tvalid || s_beat_taken)) begin
            s_beat_taken = 0;
            nv = 1'b0;
            if (tx_gap > 0)
                tx_gap--;
            else if (pending_samples.size() != 0) begin
                if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
                    tx_gap = $urandom_range(0, 17);
                else begin
                    ns = pending_samples.pop_front();
                    nv = 1'b1;
                end
            end
        end
        shown = ns;
        i_s_tvalid <= nv;
        i_s_tdata  <= {ns.y, ns.x, ns.value};
        i_s_tlast  <= ns.last;
    end

    always @(negedge i_clk) begin : drive_ready
        logic nr;
        if (rx_hold > 0) begin
            rx_hold--;
            nr = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            nr = 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_gap = $urandom_range(0, 17);
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        i_m_tready <= nr;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_POLARITY: cfg.polarity  = val[0];
            REG_PICK:     cfg.pick      = t_pick'(val[1:0]);
            REG_THRESH:   cfg.threshold = val[THR_W-1:0];
            REG_SUBPIX:   cfg.subpixel  = val[0];
            default:      ;
        endcase
    endtask

    task automatic set_config(input logic pol, input t_pick pick, input logic [THR_W-1:0] thr,
                              input logic sub);
        write_reg(REG_POLARITY, APB_DW'(pol));
        write_reg(REG_PICK,     APB_DW'(pick));
        write_reg(REG_THRESH,   APB_DW'(thr));
        write_reg(REG_SUBPIX,   APB_DW'(sub));
    endtask

    task automatic queue_sample(input logic [VALUE_W-1:0] v, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic last);
        t_sample s;
        s = '{last: last, y: y, x: x, value: v};
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // Drain: all beats sent and every report back, then let the pipeline settle.
    task automatic finish_phase();
        while (pending_samples.size() != 0 || i_s_tvalid || edge_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Steps cluster around the threshold so both hits and near misses show up.
    function automatic logic [VALUE_W-1:0] next_value(logic [VALUE_W-1:0] prev);
        int step;
        int nv;
        case ($urandom_range(0, 9))
            0, 1:    return VALUE_W'($urandom);
            2:       return prev;
            default: begin
                step = int'(cfg.threshold) * 256 + int'($urandom_range(0, 600)) - 300;
                if ($urandom_range(0, 1) == 1)
                    step = -step;
                nv = int'(prev) + step;
                if (nv < 0)
                    nv = 0;
                if (nv > 65535)
                    nv = 65535;
                return VALUE_W'(nv);
            end
        endcase
    endfunction

    task automatic gen_profile(input int len);
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom);
        for (int i = 0; i < len; i++) begin
            queue_sample(v, COORD_W'($urandom), COORD_W'($urandom), i == len - 1);
            v = next_value(v);
        end
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    initial begin
        int made;
        int target;
        int len;
        bit pressure;
        bit closing;
        logic [THR_W-1:0] thr;

        clear_profile();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config: lone sample, full-scale rise, zero step, fall before rise.
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        queue_sample(16'h04D2, 20'h00010, 20'h00020, 1'b1);
        queue_sample(16'h0000, 20'h00000, 20'h00000, 1'b0);
        queue_sample(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
        queue_sample(16'h01F4, 20'hFFFFF, 20'h00000, 1'b0);
        queue_sample(16'h01F4, 20'h12345, 20'hABCDE, 1'b1);
        queue_sample(16'h012C, 20'h00100, 20'h00200, 1'b0);
        queue_sample(16'h00C8, 20'h00180, 20'h00280, 1'b0);
        queue_sample(16'h0190, 20'h00200, 20'h00300, 1'b1);
        finish_phase();

        // Maximum threshold, falling, keep last, point at the later sample.
        set_config(POL_FALLING, PICK_LAST, 8'hFF, 1'b0);
        queue_sample(16'hFFFF, 20'h00001, 20'h80000, 1'b0);
        queue_sample(16'h0000, 20'h00002, 20'h40000, 1'b0);
        queue_sample(16'hFFFF, 20'h00003, 20'h20000, 1'b0);
        queue_sample(16'h00FF, 20'hFFFFE, 20'h10000, 1'b1);
        finish_phase();

        // Strongest with a tie, then a step one count under the threshold.
        set_config(POL_RISING, PICK_STRONGEST, 8'd1, 1'b1);
        queue_sample(16'h0000, 20'h00010, 20'h00010, 1'b0);
        queue_sample(16'h0200, 20'h00011, 20'h00013, 1'b0);
        queue_sample(16'h0000, 20'h00012, 20'h00015, 1'b0);
        queue_sample(16'h0200, 20'h00013, 20'h00017, 1'b1);
        queue_sample(16'h0000, 20'h55555, 20'hAAAAA, 1'b0);
        queue_sample(16'h00FF, 20'hAAAAA, 20'h55555, 1'b1);
        finish_phase();

        // Unused pick code acts as strongest.
        set_config(POL_FALLING, PICK_RESERVED, 8'd0, 1'b1);
        queue_sample(16'h03E8, 20'h00400, 20'h00800, 1'b0);
        queue_sample(16'h0384, 20'h00401, 20'h00801, 1'b0);
        queue_sample(16'h01F4, 20'h00403, 20'h00803, 1'b0);
        queue_sample(16'h0258, 20'h00407, 20'h00807, 1'b1);
        finish_phase();

        // One long profile, edges only at the tail.
        set_config(POL_RISING, PICK_LAST, 8'd1, 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < LONG_PROFILE; i++)
            queue_sample((i >= LONG_PROFILE - 10 && i % 2 == 1) ? 16'h8000 : 16'h0000,
                         COORD_W'(i), COORD_W'(20'hFFFFF - i), i == LONG_PROFILE - 1);
        finish_phase();

        made = 0;
        for (int ph = 0; made < RANDOM_ITEMS; ph++) begin
            target   = made + PHASE_ITEMS;
            pressure = (ph == 3);
            closing  = (target >= RANDOM_ITEMS);
            if (ph == 0)
                thr = 8'd0;
            else if (ph == 1)
                thr = 8'hFF;
            else if (ph % 2 == 0)
                thr = THR_W'($urandom_range(0, 3));
            else
                thr = THR_W'($urandom_range(0, 255));
            set_config(1'($urandom_range(0, 1)), t_pick'($urandom_range(0, 3)), thr,
                       1'($urandom_range(0, 1)));
            tx_idle_pct = (pressure || closing) ? 0 : pick_idle_pct();
            rx_idle_pct = closing ? 0 : pick_idle_pct();
            // hold off results so the output buffer fills and the sample side stalls
            if (pressure)
                rx_hold = 400;
            while (made < target) begin
                if (pressure)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(1, 12);
                gen_profile(len);
                made += len;
            end
            finish_phase();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && edge_reports_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pel_pkg.sv
hw/rtl/pel_cfg_regs.sv
hw/rtl/pel_edge_core.sv
hw/rtl/pel_out_fifo.sv
hw/rtl/profile_edge_locator.sv
bench/testbench.sv
